>>> hdl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define VCT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is low.
`define VCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

>>> hdl/vct_pkg.sv
`timescale 1ns / 1ps
package vct_pkg;

    localparam int CLIENTS      = 16;
    localparam int COUNTER_BITS = 32;

    localparam int CMD_W    = 3;
    localparam int ID_W     = 4;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;

    localparam int ROW_W  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int CNT_W  = $clog2(CLIENTS + 1);
    localparam int ADDR_W = 2 * ROW_W;
    localparam int CMP_W  = (CNT_W > ID_W) ? CNT_W : ID_W;

    typedef logic [COUNTER_BITS-1:0] t_counter;
    typedef logic [ROW_W-1:0]        t_row;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [ADDR_W-1:0]       t_addr;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_LOCAL  = 3'd2,
        CMD_SEND   = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BAD_ID = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_BUMP_RD,
        S_BUMP_WR,
        S_SWEEP,
        S_READ,
        S_FIN
    } t_state;

    typedef struct packed {
        logic use_max;
        logic inc;
    } t_alu_op;

    typedef struct packed {
        logic  en;
        t_addr addr_a;
        t_addr addr_b;
    } t_mem_rd;

    typedef struct packed {
        logic  en;
        t_addr addr;
    } t_mem_wr;

endpackage

>>> hdl/vct_ifs.sv
`timescale 1ns / 1ps
interface vct_cmd_if;
    import vct_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   first_client;
    logic [ID_W-1:0]   second_client;

    modport source (output valid, command, first_client, second_client, input ready);
    modport sink   (input valid, command, first_client, second_client, output ready);
endinterface

interface vct_res_if;
    import vct_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     entry_index;
    logic [VALUE_W-1:0]  entry_value;
    logic                last;

    modport source (output valid, status, entry_index, entry_value, last, input ready);
    modport sink   (input valid, status, entry_index, entry_value, last, output ready);
endinterface

>>> hdl/vct_ram.sv
`timescale 1ns / 1ps
module vct_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [DATA_W-1:0] o_rdata_a,
    output logic [DATA_W-1:0] o_rdata_b
);
    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

>>> hdl/vct_alu.sv
`timescale 1ns / 1ps
module vct_alu (
    input  vct_pkg::t_counter i_x,
    input  vct_pkg::t_counter i_y,
    input  vct_pkg::t_alu_op  i_op,
    output vct_pkg::t_counter o_res
);
    import vct_pkg::*;

    t_counter w_max;

    // optional max, then optional saturating increment
    always_comb begin
        w_max = (i_op.use_max && (i_y > i_x)) ? i_y : i_x;
        o_res = (i_op.inc && (w_max != '1)) ? w_max + t_counter'(1) : w_max;
    end
endmodule

>>> hdl/vct_ctrl.sv
`timescale 1ns / 1ps
module vct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    vct_cmd_if.sink           i_cmd,
    vct_res_if.source         o_res,
    output vct_pkg::t_mem_rd  o_rd,
    output vct_pkg::t_mem_wr  o_wr,
    input  vct_pkg::t_counter i_rdata_a,
    input  vct_pkg::t_counter i_rdata_b,
    output vct_pkg::t_counter o_alu_x,
    output vct_pkg::t_counter o_alu_y,
    output vct_pkg::t_alu_op  o_alu_op,
    input  vct_pkg::t_counter i_alu_res
);
    import vct_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_count              r_active;
    t_count              n_active;
    logic [CMD_W-1:0]    r_cmd;
    t_row                r_ra;
    t_row                r_rb;
    t_count              r_col;
    t_count              n_col;
    logic                r_dv;
    logic                n_dv;
    t_count              r_dcol;
    logic                r_o_valid;
    logic                n_o_valid;
    t_status             r_o_status;
    logic [ID_W-1:0]     r_o_index;
    logic [VALUE_W-1:0]  r_o_value;
    logic                r_o_last;

    logic                w_out_free;
    logic                w_accept;
    logic                w_full;
    logic                w_a_ok;
    logic                w_send_ok;
    logic                w_issue;
    logic                w_emit;
    t_status             w_emit_status;
    logic [ID_W-1:0]     w_emit_index;
    logic [VALUE_W-1:0]  w_emit_value;
    logic                w_emit_last;

    assign w_out_free = !r_o_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_full     = (r_active == CNT_W'(CLIENTS));
    assign w_a_ok     = CMP_W'(i_cmd.first_client) < CMP_W'(r_active);
    assign w_send_ok  = w_a_ok && (CMP_W'(i_cmd.second_client) < CMP_W'(r_active))
                        && (i_cmd.first_client != i_cmd.second_client);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.command)
                        CMD_ADD:   if (!w_full) n_state = S_ZERO;
                        CMD_LOCAL: if (w_a_ok) n_state = S_BUMP_RD;
                        CMD_SEND:  if (w_send_ok) n_state = S_BUMP_RD;
                        CMD_READ:  if (w_a_ok) n_state = S_READ;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_ZERO:    if (r_col == CNT_W'(CLIENTS - 1)) n_state = S_FIN;
            S_BUMP_RD: n_state = S_BUMP_WR;
            S_BUMP_WR: n_state = (r_cmd == CMD_SEND) ? S_SWEEP : S_FIN;
            S_SWEEP:   if (!w_issue && !r_dv) n_state = S_FIN;
            S_READ:    if (!w_issue && !r_dv) n_state = S_IDLE;
            S_FIN:     if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory, unit and result control
    always_comb begin
        w_issue       = 1'b0;
        o_rd          = '0;
        o_wr          = '0;
        o_alu_x       = i_rdata_a;
        o_alu_y       = i_rdata_b;
        o_alu_op      = '0;
        w_emit        = 1'b0;
        w_emit_status = ST_DONE;
        w_emit_index  = '0;
        w_emit_value  = '0;
        w_emit_last   = 1'b1;
        n_active      = r_active;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.command)
                        CMD_ADD: begin
                            if (w_full) begin
                                w_emit        = 1'b1;
                                w_emit_status = ST_FULL;
                            end else begin
                                n_active = r_active + t_count'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            w_emit = 1'b1;
                            if (r_active == '0) begin
                                w_emit_status = ST_EMPTY;
                            end else begin
                                n_active = r_active - t_count'(1);
                            end
                        end
                        CMD_LOCAL, CMD_READ: begin
                            if (!w_a_ok) begin
                                w_emit        = 1'b1;
                                w_emit_status = ST_BAD_ID;
                            end
                        end
                        CMD_SEND: begin
                            if (!w_send_ok) begin
                                w_emit        = 1'b1;
                                w_emit_status = ST_BAD_ID;
                            end
                        end
                        default: w_emit = 1'b1;
                    endcase
                end
            end
            S_ZERO: begin
                // a new row is cleared here, so the memory never needs a reset pass
                o_wr.en   = 1'b1;
                o_wr.addr = {r_ra, r_col[ROW_W-1:0]};
                o_alu_x   = '0;
            end
            S_BUMP_RD: begin
                o_rd.en     = 1'b1;
                o_rd.addr_a = {r_ra, r_ra};
            end
            S_BUMP_WR: begin
                o_wr.en      = 1'b1;
                o_wr.addr    = {r_ra, r_ra};
                o_alu_op.inc = 1'b1;
            end
            S_SWEEP: begin
                // read column i of both rows while column i-1 is written back
                w_issue          = (r_col < r_active);
                o_rd.en          = w_issue;
                o_rd.addr_a      = {r_ra, r_col[ROW_W-1:0]};
                o_rd.addr_b      = {r_rb, r_col[ROW_W-1:0]};
                o_wr.en          = r_dv;
                o_wr.addr        = {r_rb, r_dcol[ROW_W-1:0]};
                o_alu_op.use_max = 1'b1;
                o_alu_op.inc     = (r_dcol[ROW_W-1:0] == r_rb);
            end
            S_READ: begin
                w_issue      = (r_col < CNT_W'(CLIENTS)) && (!r_dv || w_out_free);
                o_rd.en      = w_issue;
                o_rd.addr_a  = {r_ra, r_col[ROW_W-1:0]};
                w_emit       = r_dv && w_out_free;
                w_emit_index = ID_W'(r_dcol);
                w_emit_value = VALUE_W'(i_alu_res);
                w_emit_last  = (r_dcol == CNT_W'(CLIENTS - 1));
            end
            S_FIN: w_emit = w_out_free;
            default: w_emit = 1'b0;
        endcase
    end

    always_comb begin
        n_col = r_col;
        if (w_accept) begin
            n_col = '0;
        end else if ((r_state == S_ZERO) || w_issue) begin
            n_col = r_col + t_count'(1);
        end
        if (w_issue) begin
            n_dv = 1'b1;
        end else if ((r_state == S_SWEEP) || w_emit) begin
            n_dv = 1'b0;
        end else begin
            n_dv = r_dv;
        end
        if (w_emit) begin
            n_o_valid = 1'b1;
        end else if (o_res.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_col     <= '0;
            r_dv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_col     <= n_col;
            r_dv      <= n_dv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.command;
            r_ra  <= (i_cmd.command == CMD_ADD) ? ROW_W'(r_active) : ROW_W'(i_cmd.first_client);
            r_rb  <= ROW_W'(i_cmd.second_client);
        end
        if (w_issue) begin
            r_dcol <= r_col;
        end
        if (w_emit) begin
            r_o_status <= w_emit_status;
            r_o_index  <= w_emit_index;
            r_o_value  <= w_emit_value;
            r_o_last   <= w_emit_last;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.status      = r_o_status;
    assign o_res.entry_index = r_o_index;
    assign o_res.entry_value = r_o_value;
    assign o_res.last        = r_o_last;
endmodule

>>> hdl/vector_clock_table_top.sv
`timescale 1ns / 1ps
// Table of vector clocks, one row of saturating counters per active client, held in a
// two-read, one-write memory and worked on one column per cycle by a single
// max/increment unit. Remove, unused codes and rejected commands answer in the cycle after
// they are taken. Add clears the new row column by column; local event bumps the sender's
// own counter; send bumps the sender, then runs a sweep that reads both rows and writes the
// receiver back, one column per cycle; a valid read streams CLIENTS items, one per cycle
// while the sink keeps ready high. The table needs no clearing pass after reset, because
// every row is cleared when it is added. A new item is taken only when the previous one has
// finished and its last item can be loaded or has left the output register.
module vector_clock_table_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vct_cmd_if.sink   i_cmd,
    vct_res_if.source o_res
);
    import vct_pkg::*;

    t_mem_rd  w_rd;
    t_mem_wr  w_wr;
    t_counter w_rdata_a;
    t_counter w_rdata_b;
    t_counter w_alu_x;
    t_counter w_alu_y;
    t_alu_op  w_alu_op;
    t_counter w_alu_res;

    vct_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .o_rd      (w_rd),
        .o_wr      (w_wr),
        .i_rdata_a (w_rdata_a),
        .i_rdata_b (w_rdata_b),
        .o_alu_x   (w_alu_x),
        .o_alu_y   (w_alu_y),
        .o_alu_op  (w_alu_op),
        .i_alu_res (w_alu_res)
    );

    vct_alu u_alu (
        .i_x   (w_alu_x),
        .i_y   (w_alu_y),
        .i_op  (w_alu_op),
        .o_res (w_alu_res)
    );

    vct_ram #(
        .DATA_W (COUNTER_BITS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_wr.en),
        .i_waddr   (w_wr.addr),
        .i_wdata   (w_alu_res),
        .i_re      (w_rd.en),
        .i_raddr_a (w_rd.addr_a),
        .i_raddr_b (w_rd.addr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );
endmodule

>>> hdl/vct_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vct_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [vct_pkg::STATUS_W-1:0] i_status,
    input logic [vct_pkg::ID_W-1:0]     i_index,
    input logic [vct_pkg::VALUE_W-1:0]  i_value,
    input logic                         i_last
);
    import vct_pkg::*;

    `VCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_index) && $stable(i_value) && $stable(i_last))

    // an item is never taken while a result sits stalled
    `VCT_ASSERT_IMPL(a_no_take_on_stall, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_out_valid || i_out_ready)

    // failures are single, empty results
    `VCT_ASSERT_IMPL(a_fail_single, i_clk, i_rst_n, i_out_valid && (i_status != ST_DONE), i_last && (i_index == '0) && (i_value == '0))

    // a read row in flight keeps the input closed
    `VCT_ASSERT_NEXT(a_read_busy, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last, !i_in_ready)
endmodule

bind vector_clock_table_top vct_checker u_vct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_index     (o_res.entry_index),
    .i_value     (o_res.entry_value),
    .i_last      (o_res.last)
);
